@@ rtl/ait_pkg.sv @@
// ----------------------------------------------------------------------------
// ait_pkg: shared types and codes for the archive index table
// Operation and status codes, request and response items, and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ait_pkg;

	localparam int ENTRIES_DEF = 256;
	localparam int COUNT_OUT_W = 9;

	// Operation codes
	localparam logic [1:0] OP_ADD            = 2'd0;
	localparam logic [1:0] OP_REMOVE         = 2'd1;
	localparam logic [1:0] OP_REMOVE_COMPACT = 2'd2;
	localparam logic [1:0] OP_LOOKUP         = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_DUP       = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] entry_id;
		logic [31:0]        entry_length;
	} req_item_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [31:0]            found_offset;
		logic [31:0]            found_length;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic [31:0]            body_total;
	} rsp_item_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic scan_start;
		logic pack_start;
		logic commit;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sweep_done;
		logic pack_needed;
		logic out_free;
	} dp_sts_t;

endpackage

@@ rtl/ait_ctrl.sv @@
// ----------------------------------------------------------------------------
// ait_ctrl: sequencing controller for the archive index table
// Accepts one item at a time, runs the search sweep, an optional offset
// compaction sweep, and commits the result once the response register frees.
// ----------------------------------------------------------------------------
module ait_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ait_pkg::dp_sts_t  sts,
	output ait_pkg::ctl_cmd_t cmd
);
	import ait_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_APPLY  = 3'd2;
	localparam logic [2:0] S_PACK   = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Take new items only when idle
	assign req_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load       = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.sweep_done) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				if (sts.pack_needed) begin
					cmd.pack_start = 1'b1;
					state_d        = S_PACK;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_PACK: begin
				if (sts.sweep_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A sweep only finishes while one is being waited on
	a_sweep_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sts.sweep_done |-> (state_q == S_SCAN || state_q == S_PACK))
		else $error("sweep finished outside a sweep state");

endmodule

@@ rtl/ait_datapath.sv @@
// ----------------------------------------------------------------------------
// ait_datapath: slot memories, sweep pipeline and result register
// Holds the id, offset and length memories, the valid bits, the count and
// the body total; sweeps the slots for search and compaction.
// ----------------------------------------------------------------------------
module ait_datapath #(
	parameter int ENTRIES = ait_pkg::ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ait_pkg::req_item_t req,
	input  ait_pkg::ctl_cmd_t  cmd,
	output ait_pkg::dp_sts_t   sts,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output ait_pkg::rsp_item_t rsp
);
	import ait_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	// Slot memories
	logic [31:0] id_mem  [ENTRIES];
	logic [31:0] off_mem [ENTRIES];
	logic [31:0] len_mem [ENTRIES];

	logic [ENTRIES-1:0] slot_valid_q;
	logic [CNT_W-1:0]   count_q;
	logic [31:0]        total_q;

	// Current item
	logic [1:0]  op_q;
	logic [31:0] id_q;
	logic [31:0] len_q;

	// Sweep address side
	logic             rd_act_q;
	logic             pack_q;
	logic [IDX_W-1:0] rd_idx_q;

	// Sweep data side
	logic             rd_vld_s1;
	logic             last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             slot_vld_s1;
	logic [31:0]      id_rd_s1;
	logic [31:0]      off_rd_s1;
	logic [31:0]      len_rd_s1;

	// Search results
	logic             hit_q;
	logic             free_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [31:0]      roff_q;
	logic [31:0]      rlen_q;

	// Result register
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	// Commit decision
	logic [1:0]       st_c;
	logic [31:0]      off_c;
	logic [31:0]      len_c;
	logic [31:0]      total_c;
	logic [CNT_W-1:0] count_c;
	logic             add_wr;
	logic             rem_wr;
	logic             pack_wr;

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.operation;
			id_q  <= req.entry_id;
			len_q <= req.entry_length;
		end
	end

	// Step the sweep address over every slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_q  <= 1'b0;
			rd_idx_q  <= '0;
			pack_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_act_q;
			last_s1   <= rd_act_q && (rd_idx_q == LAST_IDX);
			if (cmd.scan_start || cmd.pack_start) begin
				rd_act_q <= 1'b1;
				rd_idx_q <= '0;
				pack_q   <= cmd.pack_start;
			end else if (rd_act_q) begin
				if (rd_idx_q == LAST_IDX) begin
					rd_act_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
			end
		end
	end

	// Read the slot under the sweep address
	always_ff @(posedge clk) begin
		idx_s1      <= rd_idx_q;
		slot_vld_s1 <= slot_valid_q[rd_idx_q];
		id_rd_s1    <= id_mem[rd_idx_q];
		off_rd_s1   <= off_mem[rd_idx_q];
		len_rd_s1   <= len_mem[rd_idx_q];
	end

	// Record the matching slot and the lowest free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			roff_q     <= '0;
			rlen_q     <= '0;
		end else if (cmd.scan_start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (rd_vld_s1 && !pack_q) begin
			if (slot_vld_s1 && (id_rd_s1 == id_q)) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
				roff_q    <= off_rd_s1;
				rlen_q    <= len_rd_s1;
			end
			if (!slot_vld_s1 && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
	end

	// Lower offsets above the removed body during compaction
	assign pack_wr = rd_vld_s1 && pack_q && slot_vld_s1 && (off_rd_s1 > roff_q);

	// Work out the outcome of the current item
	always_comb begin
		st_c    = ST_OK;
		off_c   = '0;
		len_c   = '0;
		total_c = total_q;
		count_c = count_q;
		unique case (op_q)
			OP_ADD: begin
				if (hit_q) begin
					st_c = ST_DUP;
				end else if (!free_q) begin
					st_c = ST_FULL;
				end else begin
					off_c   = total_q;
					total_c = total_q + len_q;
					count_c = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE, OP_REMOVE_COMPACT: begin
				if (!hit_q) begin
					st_c = ST_NOT_FOUND;
				end else begin
					len_c   = rlen_q;
					total_c = total_q - rlen_q;
					count_c = count_q - CNT_W'(1);
				end
			end
			OP_LOOKUP: begin
				if (!hit_q) begin
					st_c = ST_NOT_FOUND;
				end else begin
					off_c = roff_q;
					len_c = rlen_q;
				end
			end
		endcase
	end

	assign add_wr = cmd.commit && (op_q == OP_ADD) && !hit_q && free_q;
	assign rem_wr = cmd.commit && hit_q &&
		((op_q == OP_REMOVE) || (op_q == OP_REMOVE_COMPACT));

	// Write the id and length memories on a successful add
	always_ff @(posedge clk) begin
		if (add_wr) begin
			id_mem[free_idx_q]  <= id_q;
			len_mem[free_idx_q] <= len_q;
		end
	end

	// Write the offset memory on add or compaction
	always_ff @(posedge clk) begin
		if (add_wr) begin
			off_mem[free_idx_q] <= total_q;
		end else if (pack_wr) begin
			off_mem[idx_s1] <= off_rd_s1 - rlen_q;
		end
	end

	// Update valid bits, count and total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			count_q      <= '0;
			total_q      <= '0;
		end else begin
			if (add_wr) begin
				slot_valid_q[free_idx_q] <= 1'b1;
			end
			if (rem_wr) begin
				slot_valid_q[hit_idx_q] <= 1'b0;
			end
			if (cmd.commit) begin
				count_q <= count_c;
				total_q <= total_c;
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status       <= st_c;
			rsp_q.found_offset <= off_c;
			rsp_q.found_length <= len_c;
			rsp_q.entry_count  <= COUNT_OUT_W'(count_c);
			rsp_q.body_total   <= total_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sts.sweep_done  = rd_vld_s1 && last_s1;
	assign sts.pack_needed = (op_q == OP_REMOVE_COMPACT) && hit_q;
	assign sts.out_free    = !rsp_valid_q || !rsp_stall;

	// Count tracks the number of valid slots
	a_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid_q) == int'(count_q))
		else $error("entry count disagrees with valid bits");

	// No commit while a sweep is still in flight
	a_commit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rd_act_q && !rd_vld_s1))
		else $error("commit during a sweep");

	// A result appears only after a commit
	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(cmd.commit))
		else $error("result raised without a commit");

endmodule

@@ rtl/archive_index_table.sv @@
// ----------------------------------------------------------------------------
// archive_index_table: directory of archive entries with id search
// Adds, removes (optionally compacting offsets) and looks up entries held in
// on-chip slot memories; one response item per request item.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req/req_valid and are taken when req_stall is low.
//   Responses leave on rsp/rsp_valid and are taken when rsp_stall is low.
//   Every request searches all ENTRIES slots one per cycle through the
//   single read port of the slot memories before its response is raised,
//   and a compacting remove that finds its id takes a second full sweep.
//   One request is in work at a time: a new one is taken only once the
//   previous one has committed its result to the response register.
//   The response register is separate, so a request may be taken while the
//   previous response still waits; if the receiver stalls while a response
//   is already held, the finished item waits in the commit step, no new
//   request is taken, and the entry, count and total are not updated until
//   the response register frees (offsets lowered by compaction are already
//   written by then).
//   Reset clears all valid bits, the entry count and the body total at
//   once; the slot memories themselves are not cleared.
// ----------------------------------------------------------------------------
module archive_index_table #(
	parameter int ENTRIES = ait_pkg::ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  ait_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output ait_pkg::rsp_item_t rsp
);
	import ait_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// Sequencing
	ait_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and sweeps
	ait_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ sim/archive_index_table_check.sv @@
// ----------------------------------------------------------------------------
// archive_index_table_check: response checker for the archive index table
// Watches both channels, keeps its own copy of the directory, works out the
// response of every request item taken and compares it with what comes out.
// ----------------------------------------------------------------------------
module archive_index_table_check #(
	parameter int ENTRIES = ait_pkg::ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  ait_pkg::req_item_t req,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  ait_pkg::rsp_item_t rsp,
	output int                 mismatches,
	output int                 expect_left
);
	import ait_pkg::*;

	// Shadow directory
	logic [31:0] slot_tag  [ENTRIES];
	logic [31:0] slot_base [ENTRIES];
	logic [31:0] slot_len  [ENTRIES];
	bit          slot_live [ENTRIES];
	int unsigned live_count;
	logic [31:0] body_sum;

	// Responses owed, oldest first
	rsp_item_t   owed_replies [$];

	// Apply one request to the shadow directory and return its response
	function automatic rsp_item_t directory_reply(input req_item_t it);
		rsp_item_t   r;
		int          hit;
		int          free_idx;
		logic [31:0] id_bits;
		logic [31:0] roff;
		logic [31:0] rlen;
		r        = '0;
		r.status = ST_OK;
		id_bits  = it.entry_id;
		hit      = -1;
		free_idx = -1;
		// search for the id and the lowest free slot in one pass
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit < 0 && slot_live[i] && slot_tag[i] == id_bits)
				hit = i;
			if (free_idx < 0 && !slot_live[i])
				free_idx = i;
		end
		case (it.operation)
			OP_ADD: begin
				// a duplicate wins over a full directory
				if (hit >= 0) begin
					r.status = ST_DUP;
				end else if (free_idx < 0) begin
					r.status = ST_FULL;
				end else begin
					slot_tag[free_idx]  = id_bits;
					slot_base[free_idx] = body_sum;
					slot_len[free_idx]  = it.entry_length;
					slot_live[free_idx] = 1'b1;
					r.found_offset      = body_sum;
					body_sum            = body_sum + it.entry_length;
					live_count++;
				end
			end
			OP_REMOVE, OP_REMOVE_COMPACT: begin
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					roff = slot_base[hit];
					rlen = slot_len[hit];
					// close the gap: lower every offset above the removed one
					if (it.operation == OP_REMOVE_COMPACT) begin
						for (int i = 0; i < ENTRIES; i++) begin
							if (slot_live[i] && slot_base[i] > roff)
								slot_base[i] = slot_base[i] - rlen;
						end
					end
					slot_live[hit] = 1'b0;
					body_sum       = body_sum - rlen;
					live_count--;
					r.found_length = rlen;
				end
			end
			default: begin
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.found_offset = slot_base[hit];
					r.found_length = slot_len[hit];
				end
			end
		endcase
		r.entry_count = live_count[COUNT_OUT_W-1:0];
		r.body_total  = body_sum;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Compare the response taken, then log the request taken
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				slot_live[i] = 1'b0;
			live_count = 0;
			body_sum   = '0;
			owed_replies.delete();
			mismatches  = 0;
			expect_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_replies.size() == 0) begin
					mismatches++;
					$display("%0t: response with nothing owed, expected none, actual %h",
						$time, rsp);
				end else begin
					want = owed_replies.pop_front();
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("found_offset", want.found_offset, rsp.found_offset);
					check_field("found_length", want.found_length, rsp.found_length);
					check_field("entry_count", 32'(want.entry_count),
						32'(rsp.entry_count));
					check_field("body_total", want.body_total, rsp.body_total);
				end
			end
			if (req_valid && !req_stall)
				owed_replies.push_back(directory_reply(req));
			expect_left <= owed_replies.size();
		end
	end

endmodule

@@ sim/archive_index_table_test.sv @@
// ----------------------------------------------------------------------------
// archive_index_table_test: testbench for the archive index table
// Drives directed cases, a full fill and drain of the directory and a long
// random run over a small id pool, with random idling on both channels and
// one long receiver hold-off; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module archive_index_table_test;
	import ait_pkg::*;

	localparam int          ENTRIES        = ENTRIES_DEF;
	localparam int          RESET_CYCLES   = 11;
	localparam int          RANDOM_ITEMS   = 260;
	localparam int          POOL_N         = 24;
	localparam int          HOLD_AFTER     = 600;
	localparam int          HOLD_CYCLES    = 2000;
	localparam int          DRAIN_CYCLES   = 2 * ENTRIES + 64;
	localparam int          WATCHDOG_LIMIT = 20000;
	localparam logic [31:0] ID_STEP        = 32'h0101_0101;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	int          mismatches;
	int          expect_left;
	int          idle_cycles;
	int          req_taken;
	int          rsp_taken;
	int          peak_count;
	int          ops_sent [4];
	int          status_seen [4];
	bit          no_gaps;
	logic [31:0] id_pool [POOL_N];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	archive_index_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	archive_index_table_check #(.ENTRIES(ENTRIES)) CHECK (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.expect_left (expect_left)
	);

	// Count handshakes, tally statuses and track cycles without progress
	always @(posedge clk) begin
		if (arst_n && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && req_valid && !req_stall)
			req_taken <= req_taken + 1;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_taken <= rsp_taken + 1;
			status_seen[rsp.status] <= status_seen[rsp.status] + 1;
			if (int'(rsp.entry_count) > peak_count)
				peak_count <= int'(rsp.entry_count);
		end
	end

	// Give up when nothing moves for too long
	initial begin : watchdog
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 24);
		return $urandom_range(40, 200);
	endfunction

	function automatic logic [31:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return $urandom;
		if (r < 80)
			return $urandom_range(0, 255);
		if (r < 87)
			return 32'h0000_0000;
		if (r < 94)
			return 32'hFFFF_FFFF;
		return 32'h8000_0000;
	endfunction

	// Mostly ids from the pool so that adds, hits and duplicates meet
	function automatic logic [31:0] pick_id();
		if ($urandom_range(0, 99) < 85)
			return id_pool[$urandom_range(0, POOL_N - 1)];
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 38)
			return OP_ADD;
		if (r < 58)
			return OP_REMOVE;
		if (r < 72)
			return OP_REMOVE_COMPACT;
		return OP_LOOKUP;
	endfunction

	// Offer one item, hold it until taken, then idle for a random gap, which may be none
	task automatic issue(input logic [1:0] op, input logic [31:0] id,
			input logic [31:0] len);
		req_item_t item;
		int        gap;
		item.operation    = op;
		item.entry_id     = id;
		item.entry_length = len;
		ops_sent[op]++;
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		gap = no_gaps ? 0 : idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Receiver: mostly short open and stall windows, one long hold-off mid-run
	initial begin : receiver
		int open_n;
		int stall_n;
		bit held;
		held = 1'b0;
		forever begin
			rsp_stall <= 1'b0;
			if ($urandom_range(0, 9) == 0)
				open_n = $urandom_range(100, 600);
			else
				open_n = $urandom_range(1, 8);
			repeat (open_n) @(posedge clk);
			if (!held && rsp_taken >= HOLD_AFTER) begin
				held    = 1'b1;
				stall_n = HOLD_CYCLES;
			end else begin
				stall_n = idle_len();
			end
			if (stall_n > 0) begin
				rsp_stall <= 1'b1;
				repeat (stall_n) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [31:0] fill_base;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		no_gaps   = 1'b0;
		foreach (ops_sent[i])
			ops_sent[i] = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		idle_cycles = 0;
		req_taken   = 0;
		rsp_taken   = 0;
		peak_count  = 0;
		id_pool[0] = 32'h8000_0000;
		id_pool[1] = 32'h7FFF_FFFF;
		id_pool[2] = 32'h0000_0000;
		id_pool[3] = 32'hFFFF_FFFF;
		id_pool[4] = 32'h0000_0001;
		for (int i = 5; i < POOL_N; i++)
			id_pool[i] = $urandom;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty directory: nothing to find
		issue(OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
		issue(OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
		issue(OP_REMOVE_COMPACT, 32'h8000_0000, 32'h0000_0000);
		// Extreme ids and lengths, wrap of the body total, duplicate add
		issue(OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
		issue(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0010);
		issue(OP_ADD, 32'h8000_0000, 32'h0000_0005);
		issue(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(OP_ADD, 32'h0000_0000, 32'h1234_5678);
		issue(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
		issue(OP_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		// Compact away the first entry: every offset above moves by a wrap
		issue(OP_REMOVE_COMPACT, 32'h8000_0000, 32'h0000_0000);
		issue(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
		issue(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		// Reuse of the lowest free slot
		issue(OP_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000);
		issue(OP_ADD, 32'h0000_0001, 32'h8000_0000);
		issue(OP_LOOKUP, 32'h0000_0001, 32'h0000_0000);
		issue(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
		issue(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(OP_REMOVE_COMPACT, 32'h0000_0000, 32'h0000_0000);
		issue(OP_REMOVE, 32'h0000_0001, 32'h0000_0000);

		// Fill the directory, hit it full, then drain it
		fill_base = $urandom;
		for (int i = 0; i < ENTRIES; i++)
			issue(OP_ADD, fill_base + i * ID_STEP, pick_length());
		issue(OP_ADD, fill_base + ENTRIES * ID_STEP, pick_length());
		issue(OP_ADD, fill_base, pick_length());
		issue(OP_LOOKUP, fill_base + (ENTRIES / 2) * ID_STEP, 32'h0000_0000);
		issue(OP_REMOVE_COMPACT, fill_base + (ENTRIES / 2) * ID_STEP, 32'h0000_0000);
		issue(OP_ADD, fill_base + ENTRIES * ID_STEP, pick_length());
		for (int i = 0; i < ENTRIES; i++)
			issue(($urandom_range(0, 7) == 0) ? OP_REMOVE_COMPACT : OP_REMOVE,
				fill_base + i * ID_STEP, pick_length());
		issue(OP_REMOVE, fill_base + ENTRIES * ID_STEP, 32'h0000_0000);

		// Random traffic over the id pool, with some gap-free stretches
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_gaps = (n % 150) < 30;
			issue(pick_op(), pick_id(), pick_length());
		end
		no_gaps = 1'b0;
		req_valid <= 1'b0;

		// Let the last responses out, then allow for stragglers
		@(posedge clk);
		while (expect_left != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests: %0d add, %0d remove, %0d compacting remove, %0d lookup",
			req_taken, ops_sent[OP_ADD], ops_sent[OP_REMOVE],
			ops_sent[OP_REMOVE_COMPACT], ops_sent[OP_LOOKUP]);
		$display("%0d responses: %0d ok, %0d duplicate, %0d absent, %0d full, peak %0d entries",
			rsp_taken, status_seen[ST_OK], status_seen[ST_DUP],
			status_seen[ST_NOT_FOUND], status_seen[ST_FULL], peak_count);
		if (mismatches == 0 && expect_left == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ait_pkg.sv
rtl/ait_ctrl.sv
rtl/ait_datapath.sv
rtl/archive_index_table.sv
sim/archive_index_table_check.sv
sim/archive_index_table_test.sv
